// File: rtl/tdbc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the command word classifier for the delimiter checker.
// No dependencies.
package tdbc_pkg;

    localparam int LINE_W = 20;

    // result event codes
    localparam logic [3:0] EV_WARN_BEGIN = 4'd0;
    localparam logic [3:0] EV_WARN_END   = 4'd1;
    localparam logic [3:0] EV_UNOPENED   = 4'd2;
    localparam logic [3:0] EV_MISMATCH_D = 4'd3;
    localparam logic [3:0] EV_MISMATCH_N = 4'd4;
    localparam logic [3:0] EV_NO_OPEN    = 4'd5;
    localparam logic [3:0] EV_NO_CLOSE   = 4'd6;
    localparam logic [3:0] EV_LONG_NAME  = 4'd7;
    localparam logic [3:0] EV_UNCLOSED   = 4'd8;
    localparam logic [3:0] EV_OVERFLOW   = 4'd9;
    localparam logic [3:0] EV_OK         = 4'd10;

    // delimiter kinds
    localparam logic [2:0] K_BRACE   = 3'd0;
    localparam logic [2:0] K_BRACKET = 3'd1;
    localparam logic [2:0] K_DOLLAR  = 3'd2;
    localparam logic [2:0] K_DDOLLAR = 3'd3;
    localparam logic [2:0] K_ENV     = 3'd4;

    // command word classes
    localparam logic [2:0] CMD_NONE   = 3'd0;
    localparam logic [2:0] CMD_BEGIN  = 3'd1;
    localparam logic [2:0] CMD_END    = 3'd2;
    localparam logic [2:0] CMD_TYPO_B = 3'd3;
    localparam logic [2:0] CMD_TYPO_E = 3'd4;

    typedef struct packed {
        logic       eod;
        logic [7:0] c;
        logic       is_word;
        logic       is_space;
        logic       is_nl;
        logic       is_pct;
        logic       is_lbrace;
        logic       is_rbrace;
        logic       is_dollar;
        logic       is_bslash;
        logic       is_lbrack;
        logic       is_rbrack;
    } item_t;

    typedef struct packed {
        logic [3:0]        event_res;
        logic [LINE_W-1:0] line;
        logic [2:0]        opener_kind;
        logic [LINE_W-1:0] opener_line;
        logic [2:0]        closer_kind;
        logic [LINE_W-1:0] match_line;
        logic [5:0]        unclosed_count;
        logic              last;
    } result_t;

    // p holds the first five bytes of the word, n is its length
    function automatic logic [2:0] cmd_class(input logic [39:0] p, input logic [5:0] n);
        logic [2:0] r;
        r = CMD_NONE;
        case (n)
            6'd2:
            begin
                // en ed nd
                if (p == 40'h656e || p == 40'h6564 || p == 40'h6e64)
                    r = CMD_TYPO_E;
            end
            6'd3:
            begin
                if (p == 40'h656e64)
                    r = CMD_END;
                else if (p == 40'h65646e || p == 40'h6e6564)   // edn ned
                    r = CMD_TYPO_E;
            end
            6'd4:
            begin
                // begn bein bgin egin
                if (p == 40'h6265676e || p == 40'h6265696e ||
                    p == 40'h6267696e || p == 40'h6567696e)
                    r = CMD_TYPO_B;
            end
            6'd5:
            begin
                if (p == 40'h626567696e)
                    r = CMD_BEGIN;
                // begni beign bgein ebgin
                else if (p == 40'h6265676e69 || p == 40'h626569676e ||
                         p == 40'h626765696e || p == 40'h656267696e)
                    r = CMD_TYPO_B;
            end
            default:
            begin
                r = CMD_NONE;
            end
        endcase
        return r;
    endfunction

endpackage

// File: rtl/tdbc_fifo.sv
`timescale 1ns / 1ps
// Small synchronous queue used for requests and for results.
// No dependencies; DEPTH must be a power of two.
module tdbc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             rd,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW:0]      cnt_reg;
    logic             do_wr, do_rd;

    assign full  = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= wp_reg + 1'b1;
            if (do_rd)
                rp_reg <= rp_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wp_reg] <= wdata;
    end

endmodule

// File: rtl/tdbc_front.sv
`timescale 1ns / 1ps
// Front end: classifies each incoming source byte for the checker engine.
// Depends on tdbc_pkg.
module tdbc_front (
    input  logic            kind,
    input  logic [7:0]      char_code,
    output tdbc_pkg::item_t item
);

    always_comb
    begin
        item.eod       = kind;
        item.c         = char_code;
        item.is_word   = char_code inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a], 8'h2a};
        item.is_space  = char_code inside {8'h20, [8'h09:8'h0d]};
        item.is_nl     = (char_code == 8'h0a);
        item.is_pct    = (char_code == 8'h25);
        item.is_lbrace = (char_code == 8'h7b);
        item.is_rbrace = (char_code == 8'h7d);
        item.is_dollar = (char_code == 8'h24);
        item.is_bslash = (char_code == 8'h5c);
        item.is_lbrack = (char_code == 8'h5b);
        item.is_rbrack = (char_code == 8'h5d);
    end

endmodule

// File: rtl/tdbc_back.sv
`timescale 1ns / 1ps
// Back end: lexer state, opener stack, name store and result sequencing.
// Depends on tdbc_pkg.
module tdbc_back #(
    parameter int STACK_DEPTH = 32,
    parameter int MAX_NAME    = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tdbc_pkg::item_t     item_in,
    input  logic                item_empty,
    output logic                item_rd,
    output tdbc_pkg::result_t   res_data,
    output logic                res_wr,
    input  logic                res_full
);

    localparam int LINE_BITS = tdbc_pkg::LINE_W;
    localparam int IW  = $clog2(STACK_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int PW  = $clog2(MAX_NAME);
    localparam int NLW = $clog2(MAX_NAME + 1);
    localparam int NSD = STACK_DEPTH << PW;
    localparam int OLW = tdbc_pkg::LINE_W;

    localparam logic [2:0] M_NORMAL    = 3'd0;
    localparam logic [2:0] M_COMMENT   = 3'd1;
    localparam logic [2:0] M_BACKSLASH = 3'd2;
    localparam logic [2:0] M_CMD       = 3'd3;
    localparam logic [2:0] M_BSPACE    = 3'd4;
    localparam logic [2:0] M_ESPACE    = 3'd5;
    localparam logic [2:0] M_BNAME     = 3'd6;
    localparam logic [2:0] M_ENAME     = 3'd7;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_LEX     = 5'd1;
    localparam logic [4:0] S_NORM    = 5'd2;
    localparam logic [4:0] S_EMODE   = 5'd3;
    localparam logic [4:0] S_REPORT  = 5'd4;
    localparam logic [4:0] S_RWAIT   = 5'd5;
    localparam logic [4:0] S_RPT     = 5'd6;
    localparam logic [4:0] S_RNEXT   = 5'd7;
    localparam logic [4:0] S_RESOLVE = 5'd8;
    localparam logic [4:0] S_RESW    = 5'd9;
    localparam logic [4:0] S_RES     = 5'd10;
    localparam logic [4:0] S_PUSH    = 5'd11;
    localparam logic [4:0] S_COPY    = 5'd12;
    localparam logic [4:0] S_CLOSE   = 5'd13;
    localparam logic [4:0] S_SWAIT   = 5'd14;
    localparam logic [4:0] S_SCMP    = 5'd15;
    localparam logic [4:0] S_NREQ    = 5'd16;
    localparam logic [4:0] S_NCMP    = 5'd17;
    localparam logic [4:0] S_HIT     = 5'd18;
    localparam logic [4:0] S_MISS    = 5'd19;
    localparam logic [4:0] S_EMIT    = 5'd20;
    localparam logic [4:0] S_FIN     = 5'd21;

    function automatic tdbc_pkg::result_t mk(
        input logic [3:0]           ev,
        input logic [2:0]           ok,
        input logic [LINE_BITS-1:0] ol,
        input logic [2:0]           ck,
        input logic [LINE_BITS-1:0] ml,
        input logic [5:0]           uc,
        input logic [LINE_BITS-1:0] ln
    );
        tdbc_pkg::result_t r;
        r.event_res      = ev;
        r.line           = OLW'(ln);
        r.opener_kind    = ok;
        r.opener_line    = OLW'(ol);
        r.closer_kind    = ck;
        r.match_line     = OLW'(ml);
        r.unclosed_count = uc;
        r.last           = 1'b0;
        return r;
    endfunction

    // storage
    logic [2:0]           stk_kind_mem [STACK_DEPTH];
    logic [LINE_BITS-1:0] stk_line_mem [STACK_DEPTH];
    logic [NLW-1:0]       stk_nlen_mem [STACK_DEPTH];
    logic [7:0]           name_mem [NSD];
    logic [7:0]           wbuf_mem [MAX_NAME];

    logic [2:0]           stk_rd_kind_reg;
    logic [LINE_BITS-1:0] stk_rd_line_reg;
    logic [NLW-1:0]       stk_rd_nlen_reg;
    logic [7:0]           name_rd_reg;
    logic [7:0]           wbuf_rd;

    // control
    logic [4:0]           state_reg, state_next;
    logic [4:0]           ret_reg, ret_next;
    logic [2:0]           opk_reg, opk_next;
    logic [PW-1:0]        k_reg, k_next;
    logic [IW-1:0]        cur_reg, cur_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic [2:0]           mode_reg, mode_next;
    logic [5:0]           wl_reg, wl_next;
    logic [39:0]          prefix_reg, prefix_next;
    logic                 dp_reg, dp_next;
    logic                 halted_reg, halted_next;
    logic                 pend_reg, pend_next;

    // payload
    tdbc_pkg::item_t      item_reg, item_next;
    logic [2:0]           top_kind_reg, top_kind_next;
    logic [LINE_BITS-1:0] top_line_reg, top_line_next;
    logic [LINE_BITS-1:0] cand_line_reg, cand_line_next;
    tdbc_pkg::result_t    newres_reg, newres_next;
    tdbc_pkg::result_t    pres_reg, pres_next;

    logic                 stk_we, name_we, wbuf_we;
    logic [LINE_BITS-1:0] line_inc;
    logic [2:0]           cmd_cls;
    logic                 is_top;

    assign wbuf_rd  = wbuf_mem[k_reg];
    assign line_inc = (line_reg == '1) ? line_reg : line_reg + 1'b1;
    assign cmd_cls  = tdbc_pkg::cmd_class(prefix_reg, wl_reg);
    assign is_top   = (CW'(cur_reg) == count_reg);

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        opk_next       = opk_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        count_next     = count_reg;
        line_next      = line_reg;
        mode_next      = mode_reg;
        wl_next        = wl_reg;
        prefix_next    = prefix_reg;
        dp_next        = dp_reg;
        halted_next    = halted_reg;
        pend_next      = pend_reg;
        item_next      = item_reg;
        top_kind_next  = top_kind_reg;
        top_line_next  = top_line_reg;
        cand_line_next = cand_line_reg;
        newres_next    = newres_reg;
        pres_next      = pres_reg;
        stk_we         = 1'b0;
        name_we        = 1'b0;
        wbuf_we        = 1'b0;
        item_rd        = 1'b0;
        res_wr         = 1'b0;
        res_data       = pres_reg;
        res_data.last  = (state_reg == S_FIN);

        case (state_reg)
            S_IDLE:
            begin
                if (!item_empty)
                begin
                    item_rd   = 1'b1;
                    item_next = item_in;
                    if (item_in.eod)
                    begin
                        if (halted_reg)
                            state_next = S_FIN;
                        else if (dp_reg)
                        begin
                            dp_next    = 1'b0;
                            opk_next   = tdbc_pkg::K_DOLLAR;
                            ret_next   = S_EMODE;
                            state_next = S_RESOLVE;
                        end
                        else
                            state_next = S_EMODE;
                    end
                    else if (!halted_reg)
                    begin
                        if (dp_reg)
                        begin
                            dp_next    = 1'b0;
                            opk_next   = item_in.is_dollar ? tdbc_pkg::K_DDOLLAR
                                                           : tdbc_pkg::K_DOLLAR;
                            ret_next   = item_in.is_dollar ? S_FIN : S_LEX;
                            state_next = S_RESOLVE;
                        end
                        else
                            state_next = S_LEX;
                    end
                end
            end

            S_LEX:
            begin
                state_next = S_FIN;
                if (halted_reg)
                    state_next = S_FIN;
                else
                begin
                    case (mode_reg)
                        M_COMMENT:
                        begin
                            if (item_reg.is_nl)
                            begin
                                line_next = line_inc;
                                mode_next = M_NORMAL;
                            end
                        end
                        M_BACKSLASH:
                        begin
                            mode_next = M_NORMAL;
                            if (item_reg.is_lbrack)
                            begin
                                opk_next   = tdbc_pkg::K_BRACKET;
                                ret_next   = S_FIN;
                                state_next = S_PUSH;
                            end
                            else if (item_reg.is_rbrack)
                            begin
                                opk_next   = tdbc_pkg::K_BRACKET;
                                ret_next   = S_FIN;
                                state_next = S_CLOSE;
                            end
                            else if (item_reg.is_word)
                            begin
                                mode_next   = M_CMD;
                                prefix_next = 40'(item_reg.c);
                                wl_next     = 6'd1;
                            end
                            else if (item_reg.is_nl)
                                line_next = line_inc;
                        end
                        M_CMD:
                        begin
                            if (item_reg.is_word)
                            begin
                                if (wl_reg < 6'd5)
                                    prefix_next = {prefix_reg[31:0], item_reg.c};
                                if (wl_reg != 6'd63)
                                    wl_next = wl_reg + 6'd1;
                            end
                            else
                            begin
                                case (cmd_cls)
                                    tdbc_pkg::CMD_BEGIN:
                                    begin
                                        // re-run this byte as the space after the word
                                        mode_next  = M_BSPACE;
                                        state_next = S_LEX;
                                    end
                                    tdbc_pkg::CMD_END:
                                    begin
                                        mode_next  = M_ESPACE;
                                        state_next = S_LEX;
                                    end
                                    tdbc_pkg::CMD_TYPO_B:
                                    begin
                                        mode_next   = M_NORMAL;
                                        newres_next = mk(tdbc_pkg::EV_WARN_BEGIN, 3'd0, '0,
                                                         3'd0, '0, 6'd0, line_reg);
                                        ret_next    = S_NORM;
                                        state_next  = S_EMIT;
                                    end
                                    tdbc_pkg::CMD_TYPO_E:
                                    begin
                                        mode_next   = M_NORMAL;
                                        newres_next = mk(tdbc_pkg::EV_WARN_END, 3'd0, '0,
                                                         3'd0, '0, 6'd0, line_reg);
                                        ret_next    = S_NORM;
                                        state_next  = S_EMIT;
                                    end
                                    default:
                                    begin
                                        mode_next  = M_NORMAL;
                                        state_next = S_NORM;
                                    end
                                endcase
                            end
                        end
                        M_BSPACE, M_ESPACE:
                        begin
                            if (item_reg.is_space)
                            begin
                                if (item_reg.is_nl)
                                    line_next = line_inc;
                            end
                            else if (item_reg.is_lbrace)
                            begin
                                mode_next = (mode_reg == M_ESPACE) ? M_ENAME : M_BNAME;
                                wl_next   = 6'd0;
                            end
                            else
                            begin
                                newres_next = mk(tdbc_pkg::EV_NO_OPEN, 3'd0, '0, 3'd0, '0,
                                                 6'd0, line_reg);
                                halted_next = 1'b1;
                                ret_next    = S_FIN;
                                state_next  = S_EMIT;
                            end
                        end
                        M_BNAME, M_ENAME:
                        begin
                            if (item_reg.is_word)
                            begin
                                if (wl_reg >= 6'(MAX_NAME))
                                begin
                                    newres_next = mk(tdbc_pkg::EV_LONG_NAME, 3'd0, '0, 3'd0,
                                                     '0, 6'd0, line_reg);
                                    halted_next = 1'b1;
                                    ret_next    = S_FIN;
                                    state_next  = S_EMIT;
                                end
                                else
                                begin
                                    wbuf_we = 1'b1;
                                    wl_next = wl_reg + 6'd1;
                                end
                            end
                            else if (item_reg.is_rbrace)
                            begin
                                mode_next  = M_NORMAL;
                                opk_next   = tdbc_pkg::K_ENV;
                                ret_next   = S_FIN;
                                state_next = (mode_reg == M_ENAME) ? S_CLOSE : S_PUSH;
                            end
                            else
                            begin
                                newres_next = mk(tdbc_pkg::EV_NO_CLOSE, 3'd0, '0, 3'd0, '0,
                                                 6'd0, line_reg);
                                halted_next = 1'b1;
                                ret_next    = S_FIN;
                                state_next  = S_EMIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_NORM;
                        end
                    endcase
                end
            end

            S_NORM:
            begin
                state_next = S_FIN;
                mode_next  = M_NORMAL;
                if (item_reg.is_pct)
                    mode_next = M_COMMENT;
                else if (item_reg.is_nl)
                    line_next = line_inc;
                else if (item_reg.is_lbrace)
                begin
                    opk_next   = tdbc_pkg::K_BRACE;
                    ret_next   = S_FIN;
                    state_next = S_PUSH;
                end
                else if (item_reg.is_rbrace)
                begin
                    opk_next   = tdbc_pkg::K_BRACE;
                    ret_next   = S_FIN;
                    state_next = S_CLOSE;
                end
                else if (item_reg.is_dollar)
                    dp_next = 1'b1;
                else if (item_reg.is_bslash)
                    mode_next = M_BACKSLASH;
            end

            S_EMODE:
            begin
                state_next = S_REPORT;
                if (halted_reg)
                    state_next = S_FIN;
                else
                begin
                    case (mode_reg)
                        M_COMMENT:
                        begin
                            line_next = line_inc;
                        end
                        M_CMD:
                        begin
                            case (cmd_cls)
                                tdbc_pkg::CMD_BEGIN, tdbc_pkg::CMD_END:
                                begin
                                    newres_next = mk(tdbc_pkg::EV_NO_OPEN, 3'd0, '0, 3'd0,
                                                     '0, 6'd0, line_reg);
                                    halted_next = 1'b1;
                                    ret_next    = S_FIN;
                                    state_next  = S_EMIT;
                                end
                                tdbc_pkg::CMD_TYPO_B:
                                begin
                                    newres_next = mk(tdbc_pkg::EV_WARN_BEGIN, 3'd0, '0,
                                                     3'd0, '0, 6'd0, line_reg);
                                    ret_next    = S_REPORT;
                                    state_next  = S_EMIT;
                                end
                                tdbc_pkg::CMD_TYPO_E:
                                begin
                                    newres_next = mk(tdbc_pkg::EV_WARN_END, 3'd0, '0,
                                                     3'd0, '0, 6'd0, line_reg);
                                    ret_next    = S_REPORT;
                                    state_next  = S_EMIT;
                                end
                                default:
                                begin
                                    state_next = S_REPORT;
                                end
                            endcase
                        end
                        M_BSPACE, M_ESPACE:
                        begin
                            newres_next = mk(tdbc_pkg::EV_NO_OPEN, 3'd0, '0, 3'd0, '0,
                                             6'd0, line_reg);
                            halted_next = 1'b1;
                            ret_next    = S_FIN;
                            state_next  = S_EMIT;
                        end
                        M_BNAME, M_ENAME:
                        begin
                            newres_next = mk(tdbc_pkg::EV_NO_CLOSE, 3'd0, '0, 3'd0, '0,
                                             6'd0, line_reg);
                            halted_next = 1'b1;
                            ret_next    = S_FIN;
                            state_next  = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_REPORT;
                        end
                    endcase
                end
            end

            S_REPORT:
            begin
                if (count_reg == '0)
                begin
                    newres_next = mk(tdbc_pkg::EV_OK, 3'd0, '0, 3'd0, '0, 6'd0, line_reg);
                    ret_next    = S_FIN;
                    state_next  = S_EMIT;
                end
                else
                begin
                    cur_next   = IW'(count_reg - 1'b1);
                    state_next = S_RWAIT;
                end
            end

            S_RWAIT:
            begin
                state_next = S_RPT;
            end

            S_RPT:
            begin
                newres_next = mk(tdbc_pkg::EV_UNCLOSED, stk_rd_kind_reg, stk_rd_line_reg,
                                 3'd0, '0, 6'd0, line_reg);
                ret_next    = (cur_reg == '0) ? S_FIN : S_RNEXT;
                state_next  = S_EMIT;
            end

            S_RNEXT:
            begin
                cur_next   = cur_reg - 1'b1;
                state_next = S_RWAIT;
            end

            S_RESOLVE:
            begin
                if (count_reg == '0)
                    state_next = S_PUSH;
                else
                begin
                    cur_next   = IW'(count_reg - 1'b1);
                    state_next = S_RESW;
                end
            end

            S_RESW:
            begin
                state_next = S_RES;
            end

            S_RES:
            begin
                // same kind on top closes it, otherwise a new opener
                if (stk_rd_kind_reg == opk_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = ret_reg;
                end
                else
                    state_next = S_PUSH;
            end

            S_PUSH:
            begin
                if (count_reg >= CW'(STACK_DEPTH))
                begin
                    newres_next = mk(tdbc_pkg::EV_OVERFLOW, opk_reg, line_reg, 3'd0, '0,
                                     6'd0, line_reg);
                    halted_next = 1'b1;
                    ret_next    = S_FIN;
                    state_next  = S_EMIT;
                end
                else
                begin
                    stk_we = 1'b1;
                    if (opk_reg == tdbc_pkg::K_ENV && wl_reg != 6'd0)
                    begin
                        k_next     = '0;
                        state_next = S_COPY;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        state_next = ret_reg;
                    end
                end
            end

            S_COPY:
            begin
                name_we = 1'b1;
                if (6'(k_reg) == wl_reg - 6'd1)
                begin
                    count_next = count_reg + 1'b1;
                    state_next = ret_reg;
                end
                else
                    k_next = k_reg + 1'b1;
            end

            S_CLOSE:
            begin
                if (count_reg == '0)
                begin
                    newres_next = mk(tdbc_pkg::EV_UNOPENED, 3'd0, '0, opk_reg, '0, 6'd0,
                                     line_reg);
                    halted_next = 1'b1;
                    ret_next    = S_FIN;
                    state_next  = S_EMIT;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    cur_next   = IW'(count_reg - 1'b1);
                    state_next = S_SWAIT;
                end
            end

            S_SWAIT:
            begin
                state_next = S_SCMP;
            end

            S_SCMP:
            begin
                cand_line_next = stk_rd_line_reg;
                if (is_top)
                begin
                    top_kind_next = stk_rd_kind_reg;
                    top_line_next = stk_rd_line_reg;
                end
                if (stk_rd_kind_reg != opk_reg)
                    state_next = S_MISS;
                else if (opk_reg != tdbc_pkg::K_ENV)
                    state_next = S_HIT;
                else if (6'(stk_rd_nlen_reg) != wl_reg)
                    state_next = S_MISS;
                else if (wl_reg == 6'd0)
                    state_next = S_HIT;
                else
                begin
                    k_next     = '0;
                    state_next = S_NREQ;
                end
            end

            S_NREQ:
            begin
                state_next = S_NCMP;
            end

            S_NCMP:
            begin
                if (name_rd_reg != wbuf_rd)
                    state_next = S_MISS;
                else if (6'(k_reg) == wl_reg - 6'd1)
                    state_next = S_HIT;
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_NREQ;
                end
            end

            S_HIT:
            begin
                if (is_top)
                    state_next = ret_reg;
                else
                begin
                    newres_next = mk(tdbc_pkg::EV_MISMATCH_D, top_kind_reg, top_line_reg,
                                     opk_reg, cand_line_reg,
                                     6'(count_reg - CW'(cur_reg)), line_reg);
                    halted_next = 1'b1;
                    ret_next    = S_FIN;
                    state_next  = S_EMIT;
                end
            end

            S_MISS:
            begin
                if (cur_reg == '0)
                begin
                    newres_next = mk(tdbc_pkg::EV_MISMATCH_N, top_kind_reg, top_line_reg,
                                     opk_reg, '0, 6'd0, line_reg);
                    halted_next = 1'b1;
                    ret_next    = S_FIN;
                    state_next  = S_EMIT;
                end
                else
                begin
                    cur_next   = cur_reg - 1'b1;
                    state_next = S_SWAIT;
                end
            end

            S_EMIT:
            begin
                // one result is held back so the last one of a request can be marked
                if (!pend_reg || !res_full)
                begin
                    res_wr     = pend_reg;
                    pres_next  = newres_reg;
                    pend_next  = 1'b1;
                    state_next = ret_reg;
                end
            end

            S_FIN:
            begin
                if (!pend_reg || !res_full)
                begin
                    res_wr     = pend_reg;
                    pend_next  = 1'b0;
                    state_next = S_IDLE;
                    if (item_reg.eod)
                    begin
                        count_next  = '0;
                        line_next   = LINE_BITS'(1);
                        mode_next   = M_NORMAL;
                        wl_next     = 6'd0;
                        prefix_next = 40'd0;
                        dp_next     = 1'b0;
                        halted_next = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ret_reg    <= S_IDLE;
            opk_reg    <= tdbc_pkg::K_BRACE;
            k_reg      <= '0;
            cur_reg    <= '0;
            count_reg  <= '0;
            line_reg   <= LINE_BITS'(1);
            mode_reg   <= M_NORMAL;
            wl_reg     <= 6'd0;
            prefix_reg <= 40'd0;
            dp_reg     <= 1'b0;
            halted_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            opk_reg    <= opk_next;
            k_reg      <= k_next;
            cur_reg    <= cur_next;
            count_reg  <= count_next;
            line_reg   <= line_next;
            mode_reg   <= mode_next;
            wl_reg     <= wl_next;
            prefix_reg <= prefix_next;
            dp_reg     <= dp_next;
            halted_reg <= halted_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        top_kind_reg  <= top_kind_next;
        top_line_reg  <= top_line_next;
        cand_line_reg <= cand_line_next;
        newres_reg    <= newres_next;
        pres_reg      <= pres_next;
    end

    // opener stack and name store, registered reads
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_kind_mem[count_reg[IW-1:0]] <= opk_reg;
            stk_line_mem[count_reg[IW-1:0]] <= line_reg;
            stk_nlen_mem[count_reg[IW-1:0]] <= (opk_reg == tdbc_pkg::K_ENV) ?
                                               NLW'(wl_reg) : '0;
        end
        stk_rd_kind_reg <= stk_kind_mem[cur_reg];
        stk_rd_line_reg <= stk_line_mem[cur_reg];
        stk_rd_nlen_reg <= stk_nlen_mem[cur_reg];
    end

    always_ff @(posedge clk)
    begin
        if (name_we)
            name_mem[{count_reg[IW-1:0], k_reg}] <= wbuf_rd;
        name_rd_reg <= name_mem[{cur_reg, k_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (wbuf_we)
            wbuf_mem[wl_reg[PW-1:0]] <= item_reg.c;
    end

endmodule

// File: rtl/tex_delimiter_balance_checker.sv
// Timing: the engine takes a new request only once it has finished the previous one; a
// plain text byte passes through the idle, lex, normal and finish states. Stack and name
// reads are registered single-port reads, so a close examines stack entries one at a time
// and end of document reports open entries one at a time.
// Request and result queues hold 2 entries each.
// Reset: rst_n clears all control state asynchronously; stack and name memories are not
// cleared and are only read after being written.
`timescale 1ns / 1ps
module tex_delimiter_balance_checker #(
    parameter int STACK_DEPTH = 32,
    parameter int MAX_NAME    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        kind,
    input  logic [7:0]  char_code,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  event_res,
    output logic [19:0] line,
    output logic [2:0]  opener_kind,
    output logic [19:0] opener_line,
    output logic [2:0]  closer_kind,
    output logic [19:0] match_line,
    output logic [5:0]  unclosed_count,
    output logic        last
);

    localparam int IT_W = $bits(tdbc_pkg::item_t);
    localparam int RS_W = $bits(tdbc_pkg::result_t);

    tdbc_pkg::item_t   item_w, item_q;
    tdbc_pkg::result_t res_data, res_q;
    logic              item_rd, item_empty;
    logic              res_wr, res_full;

    tdbc_front u_front (
        .kind      (kind),
        .char_code (char_code),
        .item      (item_w)
    );

    tdbc_fifo #(.WIDTH(IT_W), .DEPTH(2)) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (push),
        .wdata (item_w),
        .full  (full),
        .rd    (item_rd),
        .rdata (item_q),
        .empty (item_empty)
    );

    tdbc_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .MAX_NAME    (MAX_NAME)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_q),
        .item_empty (item_empty),
        .item_rd    (item_rd),
        .res_data   (res_data),
        .res_wr     (res_wr),
        .res_full   (res_full)
    );

    tdbc_fifo #(.WIDTH(RS_W), .DEPTH(2)) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_wr),
        .wdata (res_data),
        .full  (res_full),
        .rd    (pop),
        .rdata (res_q),
        .empty (empty)
    );

    assign event_res      = res_q.event_res;
    assign line           = res_q.line;
    assign opener_kind    = res_q.opener_kind;
    assign opener_line    = res_q.opener_line;
    assign closer_kind    = res_q.closer_kind;
    assign match_line     = res_q.match_line;
    assign unclosed_count = res_q.unclosed_count;
    assign last           = res_q.last;

`ifndef ASSERT_OFF
    a_res_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_wr |-> !res_full)
        else $error("result written into a full queue");

    a_item_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        item_rd |-> !item_empty)
        else $error("request taken from an empty queue");

    a_ok_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_wr && res_data.event_res == tdbc_pkg::EV_OK) |-> res_data.last)
        else $error("ok result not marked last");
`endif

endmodule

// File: bench/tdbc_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the delimiter checker: predicts results of each accepted request
// from its own copy of the lexer and opener stack, and compares popped results. Uses tdbc_pkg.
module tdbc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        kind,
    input  logic [7:0]  char_code,
    input  logic        empty,
    input  logic        pop,
    input  logic [3:0]  event_res,
    input  logic [19:0] line,
    input  logic [2:0]  opener_kind,
    input  logic [19:0] opener_line,
    input  logic [2:0]  closer_kind,
    input  logic [19:0] match_line,
    input  logic [5:0]  unclosed_count,
    input  logic        last,
    output int          fail_count,
    output int          pending
);

    localparam int DEPTH    = 32;
    localparam int NAME_MAX = 16;

    typedef enum logic [3:0] {
        LX_TEXT, LX_COMMENT, LX_ESCAPE, LX_WORD,
        LX_BEGIN_GAP, LX_END_GAP, LX_BEGIN_NAME, LX_END_NAME
    } lex_mode_t;

    logic [2:0]        open_kind [DEPTH];
    logic [19:0]       open_line [DEPTH];
    logic [5:0]        open_nlen [DEPTH];
    logic [7:0]        open_name [DEPTH][NAME_MAX];
    int                depth;
    logic [19:0]       line_no;
    lex_mode_t         mode;
    logic [7:0]        word [NAME_MAX];
    logic [5:0]        wlen;
    logic [39:0]       prefix;
    logic              dollar_wait;
    logic              halted;
    tdbc_pkg::result_t expected_q[$];

    function automatic void restart();
        depth       = 0;
        line_no     = 20'd1;
        mode        = LX_TEXT;
        wlen        = '0;
        prefix      = '0;
        dollar_wait = 1'b0;
        halted      = 1'b0;
    endfunction

    function automatic bit is_word(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z") || c == "*";
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == " " || c == 8'h09 || c == 8'h0a || c == 8'h0b || c == 8'h0c || c == 8'h0d;
    endfunction

    function automatic bit word_is(string s);
        logic [39:0] v;
        v = '0;
        for (int i = 0; i < s.len(); i++)
            v = {v[31:0], s[i]};
        return wlen == s.len() && prefix == v;
    endfunction

    function automatic void bump_line();
        if (line_no != '1)
            line_no = line_no + 1'b1;
    endfunction

    function automatic void post(logic [3:0] ev, logic [2:0] ok, logic [19:0] ol,
                                 logic [2:0] ck, logic [19:0] ml, logic [5:0] uc);
        tdbc_pkg::result_t r;
        r = '0;
        r.event_res = ev;
        r.line = line_no;
        r.opener_kind = ok;
        r.opener_line = ol;
        r.closer_kind = ck;
        r.match_line = ml;
        r.unclosed_count = uc;
        expected_q.push_back(r);
    endfunction

    function automatic void abort(logic [3:0] ev, logic [2:0] ok, logic [19:0] ol,
                                  logic [2:0] ck, logic [19:0] ml, logic [5:0] uc);
        post(ev, ok, ol, ck, ml, uc);
        halted = 1'b1;
    endfunction

    function automatic void open_delim(logic [2:0] k);
        if (depth >= DEPTH)
        begin
            abort(tdbc_pkg::EV_OVERFLOW, k, line_no, '0, '0, '0);
            return;
        end
        open_kind[depth] = k;
        open_line[depth] = line_no;
        open_nlen[depth] = (k == tdbc_pkg::K_ENV) ? wlen : '0;
        if (k == tdbc_pkg::K_ENV)
            for (int i = 0; i < wlen; i++)
                open_name[depth][i] = word[i];
        depth++;
    endfunction

    function automatic bit entry_fits(int i, logic [2:0] k);
        if (open_kind[i] != k)
            return 0;
        if (k != tdbc_pkg::K_ENV)
            return 1;
        if (open_nlen[i] != wlen)
            return 0;
        for (int j = 0; j < wlen; j++)
            if (open_name[i][j] != word[j])
                return 0;
        return 1;
    endfunction

    function automatic void close_delim(logic [2:0] k);
        int t;
        if (depth == 0)
        begin
            abort(tdbc_pkg::EV_UNOPENED, '0, '0, k, '0, '0);
            return;
        end
        t = depth - 1;
        depth = t;
        if (entry_fits(t, k))
            return;
        for (int j = t - 1; j >= 0; j--)
            if (entry_fits(j, k))
            begin
                abort(tdbc_pkg::EV_MISMATCH_D, open_kind[t], open_line[t], k, open_line[j],
                      6'(t - j));
                return;
            end
        abort(tdbc_pkg::EV_MISMATCH_N, open_kind[t], open_line[t], k, '0, '0);
    endfunction

    function automatic void settle_dollar(logic [2:0] k);
        dollar_wait = 1'b0;
        if (depth > 0 && open_kind[depth-1] == k)
            close_delim(k);
        else
            open_delim(k);
    endfunction

    function automatic void text_char(logic [7:0] c);
        if (c == "%")
            mode = LX_COMMENT;
        else if (c == 8'h0a)
            bump_line();
        else if (c == "{")
            open_delim(tdbc_pkg::K_BRACE);
        else if (c == "}")
            close_delim(tdbc_pkg::K_BRACE);
        else if (c == "$")
            dollar_wait = 1'b1;
        else if (c == "\\")
            mode = LX_ESCAPE;
    endfunction

    function automatic void gap_char(logic [7:0] c, bit is_end);
        if (is_blank(c))
        begin
            if (c == 8'h0a)
                bump_line();
        end
        else if (c == "{")
        begin
            mode = is_end ? LX_END_NAME : LX_BEGIN_NAME;
            wlen = '0;
        end
        else
            abort(tdbc_pkg::EV_NO_OPEN, '0, '0, '0, '0, '0);
    endfunction

    function automatic void name_char(logic [7:0] c, bit is_end);
        if (is_word(c))
        begin
            if (wlen >= NAME_MAX)
            begin
                abort(tdbc_pkg::EV_LONG_NAME, '0, '0, '0, '0, '0);
                return;
            end
            word[wlen] = c;
            wlen++;
        end
        else if (c == "}")
        begin
            mode = LX_TEXT;
            if (is_end)
                close_delim(tdbc_pkg::K_ENV);
            else
                open_delim(tdbc_pkg::K_ENV);
        end
        else
            abort(tdbc_pkg::EV_NO_CLOSE, '0, '0, '0, '0, '0);
    endfunction

    function automatic void word_done(logic [7:0] c, bit at_end);
        if (word_is("begin") || word_is("end"))
        begin
            mode = word_is("end") ? LX_END_GAP : LX_BEGIN_GAP;
            if (at_end)
                abort(tdbc_pkg::EV_NO_OPEN, '0, '0, '0, '0, '0);
            else
                gap_char(c, word_is("end"));
            return;
        end
        mode = LX_TEXT;
        if (word_is("begn") || word_is("bein") || word_is("bgin") || word_is("egin") ||
            word_is("begni") || word_is("beign") || word_is("bgein") || word_is("ebgin"))
            post(tdbc_pkg::EV_WARN_BEGIN, '0, '0, '0, '0, '0);
        else if (word_is("en") || word_is("ed") || word_is("nd") || word_is("edn") ||
                 word_is("ned"))
            post(tdbc_pkg::EV_WARN_END, '0, '0, '0, '0, '0);
        if (!at_end)
            text_char(c);
    endfunction

    function automatic void take_byte(logic [7:0] c);
        if (dollar_wait)
        begin
            if (c == "$")
            begin
                settle_dollar(tdbc_pkg::K_DDOLLAR);
                return;
            end
            settle_dollar(tdbc_pkg::K_DOLLAR);
            if (halted)
                return;
        end
        case (mode)
            LX_COMMENT:
            begin
                if (c == 8'h0a)
                begin
                    bump_line();
                    mode = LX_TEXT;
                end
            end
            LX_ESCAPE:
            begin
                mode = LX_TEXT;
                if (c == "[")
                    open_delim(tdbc_pkg::K_BRACKET);
                else if (c == "]")
                    close_delim(tdbc_pkg::K_BRACKET);
                else if (is_word(c))
                begin
                    mode = LX_WORD;
                    prefix = {32'd0, c};
                    wlen = 6'd1;
                end
                else if (c == 8'h0a)
                    bump_line();
            end
            LX_WORD:
            begin
                if (is_word(c))
                begin
                    if (wlen < 5)
                        prefix = {prefix[31:0], c};
                    if (wlen < 63)
                        wlen++;
                end
                else
                    word_done(c, 0);
            end
            LX_BEGIN_GAP:  gap_char(c, 0);
            LX_END_GAP:    gap_char(c, 1);
            LX_BEGIN_NAME: name_char(c, 0);
            LX_END_NAME:   name_char(c, 1);
            default:
            begin
                mode = LX_TEXT;
                text_char(c);
            end
        endcase
    endfunction

    function automatic void close_document();
        if (halted)
        begin
            restart();
            return;
        end
        if (dollar_wait)
            settle_dollar(tdbc_pkg::K_DOLLAR);
        if (!halted)
        begin
            case (mode)
                LX_COMMENT:                bump_line();
                LX_WORD:                   word_done(8'd0, 1);
                LX_BEGIN_GAP, LX_END_GAP:  abort(tdbc_pkg::EV_NO_OPEN, '0, '0, '0, '0, '0);
                LX_BEGIN_NAME, LX_END_NAME: abort(tdbc_pkg::EV_NO_CLOSE, '0, '0, '0, '0, '0);
                default: ;
            endcase
        end
        if (!halted)
        begin
            if (depth == 0)
                post(tdbc_pkg::EV_OK, '0, '0, '0, '0, '0);
            else
                for (int i = depth - 1; i >= 0; i--)
                    post(tdbc_pkg::EV_UNCLOSED, open_kind[i], open_line[i], '0, '0, '0);
        end
        restart();
    endfunction

    task automatic compare_field(string name, logic [19:0] exp_v, logic [19:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    initial
    begin
        restart();
        fail_count = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        int before_n;
        tdbc_pkg::result_t r;
        if (rst_n)
        begin
            if (push && !full)
            begin
                before_n = expected_q.size();
                if (kind)
                    close_document();
                else if (!halted)
                    take_byte(char_code);
                if (expected_q.size() > before_n)
                begin
                    r = expected_q.pop_back();
                    r.last = 1'b1;
                    expected_q.push_back(r);
                end
            end
            if (pop && !empty)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result with no request outstanding: event_res %0d", event_res);
                    fail_count++;
                end
                else
                begin
                    r = expected_q.pop_front();
                    compare_field("event_res", r.event_res, event_res);
                    compare_field("line", r.line, line);
                    compare_field("opener_kind", r.opener_kind, opener_kind);
                    compare_field("opener_line", r.opener_line, opener_line);
                    compare_field("closer_kind", r.closer_kind, closer_kind);
                    compare_field("match_line", r.match_line, match_line);
                    compare_field("unclosed_count", r.unclosed_count, unclosed_count);
                    compare_field("last", r.last, last);
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

// File: bench/tex_delimiter_balance_checker_tb.sv
`timescale 1ns / 1ps
// Testbench top for tex_delimiter_balance_checker: clock, reset, request and result
// traffic, verdict. Depends on tdbc_pkg, the block and tdbc_checker.
module tex_delimiter_balance_checker_tb;

    localparam string WORD_CHARS =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789*";

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        kind;
    logic [7:0]  char_code;
    logic        empty;
    logic        pop;
    logic [3:0]  event_res;
    logic [19:0] line;
    logic [2:0]  opener_kind;
    logic [19:0] opener_line;
    logic [2:0]  closer_kind;
    logic [19:0] match_line;
    logic [5:0]  unclosed_count;
    logic        last;
    int          fail_count;
    int          pending;
    int          bytes_sent;
    int          rx_hold;
    bit          burst;

    tex_delimiter_balance_checker u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .kind(kind),
        .char_code(char_code), .empty(empty), .pop(pop), .event_res(event_res),
        .line(line), .opener_kind(opener_kind), .opener_line(opener_line),
        .closer_kind(closer_kind), .match_line(match_line),
        .unclosed_count(unclosed_count), .last(last)
    );

    tdbc_checker u_checker (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .kind(kind),
        .char_code(char_code), .empty(empty), .pop(pop), .event_res(event_res),
        .line(line), .opener_kind(opener_kind), .opener_line(opener_line),
        .closer_kind(closer_kind), .match_line(match_line),
        .unclosed_count(unclosed_count), .last(last),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    // one request; push stays high after acceptance unless the next one idles
    task automatic send(logic k, logic [7:0] c);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        kind <= k;
        char_code <= c;
        @(posedge clk);
        while (full) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send(1'b0, s[i]);
    endtask

    task automatic end_document();
        send(1'b1, 8'($urandom_range(0, 255)));
    endtask

    function automatic string env_name(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(WORD_CHARS[$urandom_range(0, WORD_CHARS.len() - 1)])};
        return s;
    endfunction

    function automatic string filler();
        case ($urandom_range(0, 11))
            0: return "ab ";
            1: return "\n";
            2: return "%c}{\n";
            3: return "\\x ";
            4: return "\\%";
            5: return "\\begn ";
            6: return "\\ed ";
            7: return "\\frac ";
            8: return "\\beign\n";
            9: return " \\\n";
            10: return "\\nd x";
            default: return string'(8'($urandom_range(0, 255)));
        endcase
    endfunction

    // mostly balanced document with random content, some broken or left open
    task automatic random_document();
        int    open_k[$];
        string open_n[$];
        int    steps, r, k, top;
        string nm;
        steps = $urandom_range(3, 12);
        for (int s = 0; s < steps; s++)
        begin
            r = $urandom_range(0, 99);
            top = (open_k.size() > 0) ? open_k[$] : -1;
            if (r < 35 && open_k.size() < 6)
            begin
                k = $urandom_range(0, 4);
                if ((k == tdbc_pkg::K_DOLLAR || k == tdbc_pkg::K_DDOLLAR) && top == k)
                    k = tdbc_pkg::K_BRACE;
                nm = env_name(($urandom_range(0, 29) == 0) ? 17 : $urandom_range(1, 16));
                case (k)
                    tdbc_pkg::K_BRACE:   send_text("{");
                    tdbc_pkg::K_BRACKET: send_text("\\[");
                    tdbc_pkg::K_DOLLAR:  send_text("$ ");
                    tdbc_pkg::K_DDOLLAR: send_text("$$ ");
                    default:             send_text({"\\begin{", nm, "}"});
                endcase
                open_k.push_back(k);
                open_n.push_back(nm);
            end
            else if (r < 65 && open_k.size() > 0)
            begin
                k = open_k.pop_back();
                nm = open_n.pop_back();
                if ($urandom_range(0, 9) == 0)
                    nm = env_name($urandom_range(1, 4));
                case (k)
                    tdbc_pkg::K_BRACE:   send_text("}");
                    tdbc_pkg::K_BRACKET: send_text("\\]");
                    tdbc_pkg::K_DOLLAR:  send_text("$ ");
                    tdbc_pkg::K_DDOLLAR: send_text("$$ ");
                    default:             send_text({"\\end{", nm, "}"});
                endcase
            end
            else
                send_text(filler());
        end
        if ($urandom_range(0, 9) < 7)
            while (open_k.size() > 0)
            begin
                k = open_k.pop_back();
                nm = open_n.pop_back();
                case (k)
                    tdbc_pkg::K_BRACE:   send_text("}");
                    tdbc_pkg::K_BRACKET: send_text("\\]");
                    tdbc_pkg::K_DOLLAR:  send_text("$");
                    tdbc_pkg::K_DDOLLAR: send_text("$$");
                    default:             send_text({"\\end{", nm, "}"});
                endcase
            end
        end_document();
    endtask

    // result side; a long hold-off is taken when the stimulus asks for it
    initial
    begin
        int stall;
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold > 0)
            begin
                pop <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
        end
    end

    initial
    begin
        string opens;
        push <= 1'b0;
        kind <= 1'b0;
        char_code <= 8'd0;
        rst_n <= 1'b0;
        rx_hold = 0;
        burst = 0;
        bytes_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: clean document, stray close, mismatches, typos, bad names, lookahead at end, overflow
        send_text("{\n$x$\\[\\]$$ $$\\begin{ab}\\end{ab}}");
        end_document();
        send_text("}");
        end_document();
        end_document();
        send_text("{\\[}");
        end_document();
        send_text("\\[}");
        end_document();
        send_text("\\en}");
        end_document();
        send_text("\\begin x");
        end_document();
        send_text("\\begin{a!");
        end_document();
        send_text("\\begin{abcdefghijklmnopq}");
        end_document();
        send_text("{\n\\[ $%x");
        end_document();
        send_text("\\begin");
        end_document();
        send_text("\\bgin");
        end_document();
        opens = "";
        for (int i = 0; i < 33; i++)
            opens = {opens, "{"};
        send_text(opens);
        end_document();
        send_text(opens.substr(0, 31));
        end_document();

        while (bytes_sent < 420)
        begin
            if (bytes_sent > 150 && bytes_sent < 200 && !burst)
            begin
                // long hold on the result side while requests keep coming
                rx_hold = 400;
                burst = 1;
                send_text(opens.substr(0, 31));
                end_document();
                random_document();
                burst = 0;
                // drain before carrying on
                push <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
            random_document();
        end
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0 && pending == 0 && empty)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
rtl/tdbc_pkg.sv
rtl/tdbc_fifo.sv
rtl/tdbc_front.sv
rtl/tdbc_back.sv
rtl/tex_delimiter_balance_checker.sv
bench/tdbc_checker.sv
bench/tex_delimiter_balance_checker_tb.sv
